@@ hdl/fpe_pkg.sv @@
// fpe_pkg: shared types and constants for the frame pacing estimator.
// Used by fpe_mul, fpe_seq and frame_pacing_estimator. No dependencies.

package fpe_pkg;

	localparam int SERIAL_W  = 32;
	localparam int TIME_W    = 64;
	localparam int REFRESH_W = 32;
	localparam int SWAP_W    = 8;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 32;
	localparam int MUL_W     = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_PERIOD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_SWAP = 8'd1;

	localparam logic [SWAP_W-1:0] SWAP_RESET = 8'd1;

	localparam logic FUNC_OBSERVE = 1'b0;
	localparam logic FUNC_QUERY   = 1'b1;

	typedef struct packed {
		logic [REFRESH_W-1:0] refresh_period_ns;
		logic [SWAP_W-1:0]    frames_per_swap;
	} fpe_cfg_t;

	typedef struct packed {
		logic                func;
		logic [SERIAL_W-1:0] frame_serial;
		logic [TIME_W-1:0]   time_ns;
		logic                is_wall_time;
	} fpe_item_t;

	typedef struct packed {
		logic [TIME_W-1:0] target_time_ns;
		logic              estimate_valid;
		logic              base_moved;
	} fpe_res_t;

endpackage

@@ hdl/fpe_mul.sv @@
// fpe_mul: shared 32x32 unsigned multiplier with registered product.
// Depends on fpe_pkg.

module fpe_mul (
	input  logic                        clk,
	input  logic [fpe_pkg::MUL_W-1:0]   a,
	input  logic [fpe_pkg::MUL_W-1:0]   b,
	output logic [2*fpe_pkg::MUL_W-1:0] p
);
	import fpe_pkg::*;

	logic [2*MUL_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

@@ hdl/fpe_seq.sv @@
// fpe_seq: sequencer and datapath of the frame pacing estimator.
// Holds the base estimate; drives the shared multiplier fpe_mul.
// Depends on fpe_pkg and fpe_mul.

module fpe_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  fpe_pkg::fpe_cfg_t cfg,
	input  logic              start,
	input  fpe_pkg::fpe_item_t item,
	input  logic              out_free,
	output logic              idle,
	output logic              done,
	output fpe_pkg::fpe_res_t res
);
	import fpe_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_M4,
		ST_ADD,
		ST_QSUB,
		ST_DIFF,
		ST_MAG,
		ST_FIN
	} state_t;

	state_t state_q;

	// base estimate
	logic                have_base_q;
	logic                have_disp_q;
	logic [SERIAL_W-1:0] base_frame_q;
	logic [TIME_W-1:0]   base_time_q;

	// working registers
	fpe_item_t           item_q;
	logic [SERIAL_W-1:0] dist_q;
	logic [SWAP_W-1:0]   m1hi_q;
	logic [TIME_W-1:0]   acc_q;
	logic [TIME_W-1:0]   sum_q;
	logic [TIME_W-1:0]   diff_q;
	logic                gt_ext_q;
	logic                gt_base_q;

	logic [MUL_W-1:0]    mul_a;
	logic [MUL_W-1:0]    mul_b;
	logic [2*MUL_W-1:0]  prod;

	logic [TIME_W-1:0]   half_ref;
	logic [TIME_W-1:0]   eighth_ref;
	logic                set_base;
	logic                disp_seen;

	fpe_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	always_comb begin
		unique case (state_q)
			ST_M1: begin
				mul_a = cfg.refresh_period_ns;
				mul_b = {{(MUL_W-SWAP_W){1'b0}}, cfg.frames_per_swap};
			end
			ST_M2: begin
				mul_a = prod[MUL_W-1:0];
				mul_b = dist_q;
			end
			ST_M3: begin
				mul_a = {{(MUL_W-SWAP_W){1'b0}}, m1hi_q};
				mul_b = dist_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign half_ref   = {{(TIME_W-REFRESH_W+1){1'b0}}, cfg.refresh_period_ns[REFRESH_W-1:1]};
	assign eighth_ref = {{(TIME_W-REFRESH_W+3){1'b0}}, cfg.refresh_period_ns[REFRESH_W-1:3]};

	// observe decision, evaluated in ST_FIN
	always_comb begin
		priority if (!have_base_q) begin
			set_base = 1'b1;
		end else if (item_q.is_wall_time && !have_disp_q) begin
			set_base = 1'b1;
		end else if (cfg.refresh_period_ns == '0) begin
			set_base = gt_base_q;
		end else if (dist_q == '0 || dist_q[SERIAL_W-1]) begin
			set_base = 1'b0;
		end else begin
			set_base = gt_ext_q || (diff_q < half_ref);
		end
	end

	assign disp_seen = have_base_q && !item_q.is_wall_time;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			have_base_q  <= 1'b0;
			have_disp_q  <= 1'b0;
			base_frame_q <= '0;
			base_time_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_M1;
					end
				end
				ST_M1:   state_q <= ST_M2;
				ST_M2:   state_q <= ST_M3;
				ST_M3:   state_q <= ST_M4;
				ST_M4:   state_q <= ST_ADD;
				ST_ADD:  state_q <= (item_q.func == FUNC_QUERY) ? ST_QSUB : ST_DIFF;
				ST_QSUB: state_q <= ST_FIN;
				ST_DIFF: state_q <= ST_MAG;
				ST_MAG:  state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (item_q.func == FUNC_OBSERVE) begin
							if (disp_seen) begin
								have_disp_q <= 1'b1;
							end
							if (set_base) begin
								have_base_q  <= 1'b1;
								base_frame_q <= item_q.frame_serial;
								base_time_q  <= item_q.time_ns;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					item_q <= item;
					dist_q <= item.frame_serial - base_frame_q;
				end
			end
			ST_M2: m1hi_q <= prod[MUL_W+SWAP_W-1:MUL_W];
			ST_M3: acc_q  <= prod;
			ST_M4: acc_q  <= acc_q + {prod[MUL_W-1:0], {MUL_W{1'b0}}};
			ST_ADD: sum_q <= base_time_q + acc_q;
			ST_QSUB: sum_q <= sum_q - eighth_ref;
			ST_DIFF: begin
				diff_q    <= sum_q - item_q.time_ns;
				gt_ext_q  <= item_q.time_ns > sum_q;
				gt_base_q <= item_q.time_ns > base_time_q;
			end
			ST_MAG: begin
				if (diff_q[TIME_W-1]) begin
					diff_q <= '0 - diff_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign idle = (state_q == ST_IDLE);
	assign done = (state_q == ST_FIN) && out_free;

	always_comb begin
		res.target_time_ns = '0;
		res.estimate_valid = have_base_q;
		res.base_moved     = 1'b0;
		if (item_q.func == FUNC_QUERY) begin
			if (have_base_q) begin
				res.target_time_ns = sum_q;
			end
		end else begin
			res.estimate_valid = have_base_q || set_base;
			res.base_moved     = set_base;
		end
	end

endmodule

@@ hdl/frame_pacing_estimator.sv @@
// frame_pacing_estimator: top level; configuration registers, input
// handshake and output register around the sequencer fpe_seq.
// Depends on fpe_pkg and fpe_seq.
//
// channel  direction  handshake                fields
// cfg      in         cfg_wr_en                cfg_index, cfg_wr_data
// in       in         in_valid / in_stall      func, frame_serial, time_ns, is_wall_time
// out      out        out_valid / out_stall    target_time_ns, estimate_valid, base_moved
//
// From accept to out_valid an observe steps through M1-M4 on the shared
// 32x32 multiplier, then adds and compares in ADD, DIFF and MAG on one 64-bit
// path, then FIN; a query takes ADD, QSUB and FIN. in_stall is high while an
// item is in work; the next beat is taken in the cycle after the result is
// loaded. One finished beat may wait in the output register while the next item is worked on.
// arst_n clears the base estimate, refresh period (0) and swap (1).

module frame_pacing_estimator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [fpe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fpe_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               func,
	input  logic [fpe_pkg::SERIAL_W-1:0]       frame_serial,
	input  logic [fpe_pkg::TIME_W-1:0]         time_ns,
	input  logic                               is_wall_time,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [fpe_pkg::TIME_W-1:0]         target_time_ns,
	output logic                               estimate_valid,
	output logic                               base_moved
);
	import fpe_pkg::*;

	fpe_cfg_t  cfg_q;
	fpe_item_t item;
	fpe_res_t  res;
	fpe_res_t  res_q;
	logic      out_valid_q;
	logic      seq_idle;
	logic      seq_done;
	logic      out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.refresh_period_ns <= '0;
			cfg_q.frames_per_swap   <= SWAP_RESET;
		end else if (cfg_wr_en) begin
			if (cfg_index == CFG_REFRESH_PERIOD) begin
				cfg_q.refresh_period_ns <= cfg_wr_data[REFRESH_W-1:0];
			end
			if (cfg_index == CFG_FRAMES_PER_SWAP) begin
				cfg_q.frames_per_swap <= cfg_wr_data[SWAP_W-1:0];
			end
		end
	end

	assign item.func         = func;
	assign item.frame_serial = frame_serial;
	assign item.time_ns      = time_ns;
	assign item.is_wall_time = is_wall_time;

	assign in_stall = !seq_idle;
	assign out_free = !out_valid_q || !out_stall;

	fpe_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.start    (in_valid && seq_idle),
		.item     (item),
		.out_free (out_free),
		.idle     (seq_idle),
		.done     (seq_done),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign target_time_ns = res_q.target_time_ns;
	assign estimate_valid = res_q.estimate_valid;
	assign base_moved     = res_q.base_moved;

endmodule
